// File: design/compact_key_set_table_assert.svh
// Assertion macros used by the key set table top level.
`ifndef COMPACT_KEY_SET_TABLE_ASSERT_SVH
`define COMPACT_KEY_SET_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define CKS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define CKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CKS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define CKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/cks_pkg.sv
// Package with the constants, codes and types of the key set table.
package cks_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int KEY_W       = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int ENTRY_CNT_W = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_SEARCH = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_FIN,
    S_RESP
  } state_t;

endpackage

// File: design/cks_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module cks_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/compact_key_set_table.sv
// Top level of the compact key set table: sequencer, scan counters and result register.
// A full scan of n stored keys passes S_RD and S_CMP for each entry through the single RAM
// read port, then S_FIN and S_RESP; a hit ends search and insert early; invalid ones skip
// to S_RESP. One request at a time; S_RESP waits while an unread result blocks the output.
// Reset (rst, synchronous, active high) empties the set at once through the fill count;
// no clearing pass is needed and the block is ready in the first cycle after reset.
`include "compact_key_set_table_assert.svh"

module compact_key_set_table
  import cks_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] key
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] status, [10:3] entry_count, [15:11] zero
);

  // Sequencer state and the registers it steps through a scan.
  state_t             state, state_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [CNT_W-1:0]   wr_cnt, wr_cnt_next;
  logic [CNT_W-1:0]   count, count_next;
  req_t               op, op_next;
  logic [KEY_W-1:0]   key_reg, key_next;
  logic               hit, hit_next;
  status_t            res_status, res_status_next;

  // Result register, which frees the sequencer while the result waits.
  logic               out_valid, out_valid_next;
  status_t            out_status, out_status_next;
  logic [CNT_W-1:0]   out_count, out_count_next;

  // Key RAM port signals.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;

  logic               match;
  logic               last;
  req_t               in_op;

  cks_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, ENTRY_CNT_W'(out_count), out_status};

  assign in_op = req_t'(s_tuser);
  assign match = (ram_rdata == key_reg);
  // The entry just compared is the last stored one.
  assign last  = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    wr_cnt     <= wr_cnt_next;
    op         <= op_next;
    key_reg    <= key_next;
    hit        <= hit_next;
    res_status <= res_status_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
  end

  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    wr_cnt_next     = wr_cnt;
    count_next      = count;
    op_next         = op;
    key_next        = key_reg;
    hit_next        = hit;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_count_next  = out_count;
    ram_we          = 1'b0;
    ram_waddr       = wr_cnt[IDX_W-1:0];
    ram_wdata       = ram_rdata;
    ram_raddr       = rd_idx;

    // The consumer takes the waiting result.
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next     = in_op;
          key_next    = s_tdata;
          rd_idx_next = '0;
          wr_cnt_next = '0;
          hit_next    = 1'b0;
          if (s_tdata == '0 ||
              (in_op != REQ_SEARCH && in_op != REQ_INSERT && in_op != REQ_DELETE)) begin
            res_status_next = ST_INVALID;
            state_next      = S_RESP;
          end else if (count == '0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_RD;
          end
        end
      end

      // The read of entry rd_idx is issued here; its data is compared next cycle.
      S_RD: begin
        state_next = S_CMP;
      end

      S_CMP: begin
        if (op == REQ_DELETE) begin
          // Compaction: keep every entry that differs from the key, packed from slot zero.
          if (match) begin
            hit_next = 1'b1;
          end else begin
            ram_we      = 1'b1;
            wr_cnt_next = wr_cnt + CNT_W'(1);
          end
          if (last) begin
            state_next = S_FIN;
          end else begin
            rd_idx_next = rd_idx + IDX_W'(1);
            state_next  = S_RD;
          end
        end else if (match) begin
          // Search and insert stop at the first hit.
          hit_next   = 1'b1;
          state_next = S_FIN;
        end else if (last) begin
          state_next = S_FIN;
        end else begin
          rd_idx_next = rd_idx + IDX_W'(1);
          state_next  = S_RD;
        end
      end

      S_FIN: begin
        state_next = S_RESP;
        case (op)
          REQ_SEARCH: begin
            res_status_next = hit ? ST_OK : ST_NOT_FOUND;
          end
          REQ_INSERT: begin
            if (hit) begin
              res_status_next = ST_PRESENT;
            end else if (count >= CNT_W'(TABLE_DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              // The first free slot is always the one at the fill count.
              ram_we          = 1'b1;
              ram_waddr       = count[IDX_W-1:0];
              ram_wdata       = key_reg;
              count_next      = count + CNT_W'(1);
              res_status_next = ST_OK;
            end
          end
          REQ_DELETE: begin
            count_next      = wr_cnt;
            res_status_next = hit ? ST_OK : ST_NOT_FOUND;
          end
          default: begin
            res_status_next = ST_INVALID;
          end
        endcase
      end

      S_RESP: begin
        if (!out_valid || m_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_count_next  = count;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CKS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH), "count over depth")
  `CKS_ASSERT_SAME(a_read_in_range, clk, rst, state == S_RD, CNT_W'(rd_idx) < count, "read past fill")
  `CKS_ASSERT_SAME(a_compact_order, clk, rst, state == S_CMP, wr_cnt <= CNT_W'(rd_idx), "write ahead")
  `CKS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, state != S_IDLE, "idle after accept")

endmodule
